[src/assert_macros.svh]
// Assertion helpers shared by the tracking controller modules.
// Each use expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define PTT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent implies consequent in the next cycle
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

[src/ptt_pkg.sv]
package ptt_pkg;

	// Field widths
	localparam int POS_W      = 8;
	localparam int PIX_W      = 8;
	localparam int CONF_W     = 8;
	localparam int TRIM_W     = 7;
	localparam int STATUS_W   = 2;
	localparam int ERR_W      = 9;
	localparam int SUM_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;

	// Serial divider: one quotient bit per cycle
	localparam int DIV_STEPS = POS_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Default servo center
	localparam logic [POS_W-1:0] PAN_CENTER_DEF  = 8'd127;
	localparam logic [POS_W-1:0] TILT_CENTER_DEF = 8'd127;

	// Pan error offset and clamp
	localparam logic signed [SUM_W-1:0] PAN_ERR_OFFSET = 10'sd25;
	localparam logic signed [SUM_W-1:0] PAN_ERR_MAX    = 10'sd127;
	localparam logic signed [SUM_W-1:0] PAN_ERR_MIN    = -10'sd127;

	// Tracking status codes
	localparam logic [STATUS_W-1:0] STATUS_SEARCHING = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_IN_VIEW   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ON_TARGET = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_TARGET     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_TARGET    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_ERRORS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_GAINS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LIMITS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMITS    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_SETUP   = 3'd7;

	// Register reset values
	localparam logic [7:0]  RST_CONF_THRESHOLD = 8'd50;
	localparam logic [7:0]  RST_PAN_TARGET     = 8'd80;
	localparam logic [7:0]  RST_TILT_TARGET    = 8'd120;
	localparam logic [15:0] RST_ALLOWED_ERRORS = 16'd1542;
	localparam logic [15:0] RST_AXIS_GAINS     = 16'd2056;
	localparam logic [15:0] RST_PAN_LIMITS     = 16'd65280;
	localparam logic [15:0] RST_TILT_LIMITS    = 16'd65280;
	localparam logic [25:0] RST_SEARCH_SETUP   = 26'd4928009;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic calc_err;
		logic search;
		logic div_start;
		logic tilt_sel;
		logic update;
		logic publish;
	} ptt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fresh;
		logic lock;
		logic div_done;
	} ptt_status_t;

endpackage

[src/ptt_div.sv]
`include "assert_macros.svh"

module ptt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ptt_pkg::POS_W-1:0]  dividend,
	input  logic [ptt_pkg::POS_W-1:0]  divisor,
	output logic                       busy,
	output logic                       done,
	output logic [ptt_pkg::POS_W-1:0]  quotient
);
	import ptt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [POS_W-1:0]     rem_q;
	logic [POS_W-1:0]     quo_q;
	logic [POS_W-1:0]     dvs_q;

	logic [POS_W:0]       trial;
	logic [POS_W:0]       diff;
	logic                 fits;

	// Restoring step: shift in next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[POS_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and partial results; zero divisor acts as one
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= (divisor == '0) ? POS_W'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[POS_W-1:0] : trial[POS_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	// done rises in the cycle after the last of the quotient steps
	`PTT_ASSERT(a_div_start_idle, start |-> !busy_q, "divider started while busy")
	`PTT_ASSERT(a_div_latency, start |-> ##(DIV_STEPS + 1) done_q, "divider latency mismatch")

endmodule

[src/ptt_dp.sv]
module ptt_dp #(
	parameter logic [ptt_pkg::POS_W-1:0] PAN_CENTER  = ptt_pkg::PAN_CENTER_DEF,
	parameter logic [ptt_pkg::POS_W-1:0] TILT_CENTER = ptt_pkg::TILT_CENTER_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             packet_fresh,
	input  logic [ptt_pkg::CONF_W-1:0]       confidence,
	input  logic [ptt_pkg::PIX_W-1:0]        centroid_x,
	input  logic [ptt_pkg::PIX_W-1:0]        centroid_y,
	input  logic signed [ptt_pkg::TRIM_W-1:0] pan_trim,
	input  ptt_pkg::ptt_cmd_t                cmd,
	output ptt_pkg::ptt_status_t             status,
	output logic [ptt_pkg::POS_W-1:0]        pan_position,
	output logic [ptt_pkg::POS_W-1:0]        tilt_position,
	output logic [ptt_pkg::STATUS_W-1:0]     tracking_status
);
	import ptt_pkg::*;

	// Configuration registers
	logic [7:0]  conf_thr_q;
	logic [7:0]  pan_tgt_q;
	logic [7:0]  tilt_tgt_q;
	logic [15:0] allowed_q;
	logic [15:0] gains_q;
	logic [15:0] pan_lim_q;
	logic [15:0] tilt_lim_q;
	logic [25:0] search_q;

	// Latched tick
	logic                     fresh_q;
	logic [CONF_W-1:0]        conf_q;
	logic [PIX_W-1:0]         cx_q;
	logic [PIX_W-1:0]         cy_q;
	logic signed [TRIM_W-1:0] trim_q;

	// Axis errors
	logic signed [ERR_W-1:0] pan_err_q;
	logic signed [ERR_W-1:0] tilt_err_q;

	// Controller state
	logic [POS_W-1:0]    pan_reg_q;
	logic [POS_W-1:0]    tilt_reg_q;
	logic                restart_q;
	logic [7:0]          wait_q;
	logic [STATUS_W-1:0] status_q;
	logic                pan_ok_q;

	// Result register
	logic [POS_W-1:0]    pan_out_q;
	logic [POS_W-1:0]    tilt_out_q;
	logic [STATUS_W-1:0] status_out_q;

	logic [POS_W-1:0] pan_lo, pan_hi, tilt_lo, tilt_hi;
	assign pan_lo  = pan_lim_q[7:0];
	assign pan_hi  = pan_lim_q[15:8];
	assign tilt_lo = tilt_lim_q[7:0];
	assign tilt_hi = tilt_lim_q[15:8];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_thr_q <= RST_CONF_THRESHOLD;
			pan_tgt_q  <= RST_PAN_TARGET;
			tilt_tgt_q <= RST_TILT_TARGET;
			allowed_q  <= RST_ALLOWED_ERRORS;
			gains_q    <= RST_AXIS_GAINS;
			pan_lim_q  <= RST_PAN_LIMITS;
			tilt_lim_q <= RST_TILT_LIMITS;
			search_q   <= RST_SEARCH_SETUP;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_CONF_THRESHOLD: conf_thr_q <= cfg_data[7:0];
				REG_PAN_TARGET:     pan_tgt_q  <= cfg_data[7:0];
				REG_TILT_TARGET:    tilt_tgt_q <= cfg_data[7:0];
				REG_ALLOWED_ERRORS: allowed_q  <= cfg_data[15:0];
				REG_AXIS_GAINS:     gains_q    <= cfg_data[15:0];
				REG_PAN_LIMITS:     pan_lim_q  <= cfg_data[15:0];
				REG_TILT_LIMITS:    tilt_lim_q <= cfg_data[15:0];
				REG_SEARCH_SETUP:   search_q   <= cfg_data[25:0];
				default: ;
			endcase
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fresh_q <= packet_fresh;
			conf_q  <= confidence;
			cx_q    <= centroid_x;
			cy_q    <= centroid_y;
			trim_q  <= pan_trim;
		end
	end

	// Pixel errors: pan wraps to a signed byte, adds trim, subtracts the offset, then clamps
	logic [PIX_W-1:0]        pan_diff;
	logic signed [SUM_W-1:0] pan_sum;
	logic signed [ERR_W-1:0] pan_err;
	logic signed [ERR_W-1:0] tilt_err;

	assign pan_diff = cx_q - pan_tgt_q;
	assign pan_sum  = $signed({{(SUM_W-TRIM_W){trim_q[TRIM_W-1]}}, trim_q})
		+ $signed({{(SUM_W-PIX_W){pan_diff[PIX_W-1]}}, pan_diff}) - PAN_ERR_OFFSET;
	assign tilt_err = $signed({1'b0, cy_q} - {1'b0, tilt_tgt_q});

	always_comb begin
		priority if (pan_sum > PAN_ERR_MAX) pan_err = PAN_ERR_MAX[ERR_W-1:0];
		else if (pan_sum < PAN_ERR_MIN)     pan_err = PAN_ERR_MIN[ERR_W-1:0];
		else                                pan_err = pan_sum[ERR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_err) begin
			pan_err_q  <= pan_err;
			tilt_err_q <= tilt_err;
		end
	end

	// Axis operand select
	logic signed [ERR_W-1:0] sel_err;
	logic [7:0]       sel_dead, sel_gain;
	logic             sel_rev;
	logic [POS_W-1:0] sel_lo, sel_hi, sel_pos;
	logic signed [ERR_W-1:0] err_neg_val;
	logic             err_neg;
	logic [POS_W-1:0] err_mag;
	logic             out_band;

	assign sel_err  = cmd.tilt_sel ? tilt_err_q : pan_err_q;
	assign sel_dead = cmd.tilt_sel ? allowed_q[15:8] : allowed_q[7:0];
	assign sel_gain = cmd.tilt_sel ? gains_q[15:8] : gains_q[7:0];
	assign sel_rev  = cmd.tilt_sel ? search_q[25] : search_q[24];
	assign sel_lo   = cmd.tilt_sel ? tilt_lo : pan_lo;
	assign sel_hi   = cmd.tilt_sel ? tilt_hi : pan_hi;
	assign sel_pos  = cmd.tilt_sel ? tilt_reg_q : pan_reg_q;

	assign err_neg     = sel_err[ERR_W-1];
	assign err_neg_val = -sel_err;
	assign err_mag     = err_neg ? err_neg_val[POS_W-1:0] : sel_err[POS_W-1:0];
	assign out_band    = err_mag > sel_dead;

	// Shared divider for both axes
	logic             div_busy;
	logic             div_done;
	logic [POS_W-1:0] div_quo;

	ptt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (err_mag),
		.divisor  (sel_gain),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Step and clamp to limits (minimum checked first)
	logic [POS_W-1:0]        step_mag;
	logic signed [SUM_W-1:0] pos_ext, step_ext, pos_sum, lo_ext, hi_ext;
	logic [POS_W-1:0]        new_pos;

	assign step_mag = !out_band ? '0 : ((div_quo == '0) ? POS_W'(1) : div_quo);
	assign pos_ext  = $signed({2'b00, sel_pos});
	assign step_ext = $signed({2'b00, step_mag});
	assign lo_ext   = $signed({2'b00, sel_lo});
	assign hi_ext   = $signed({2'b00, sel_hi});
	assign pos_sum  = (err_neg ^ sel_rev) ? pos_ext - step_ext : pos_ext + step_ext;

	always_comb begin
		priority if (pos_sum < lo_ext) new_pos = sel_lo;
		else if (pos_sum > hi_ext)     new_pos = sel_hi;
		else                           new_pos = pos_sum[POS_W-1:0];
	end

	// Raster search move
	logic [7:0]       wait_nx;
	logic             move;
	logic [POS_W:0]   pan_step_sum, tilt_step_sum;
	logic [POS_W-1:0] srch_pan, srch_tilt;

	assign wait_nx       = wait_q + 1'b1;
	assign move          = wait_nx > search_q[7:0];
	assign pan_step_sum  = {1'b0, pan_reg_q} + {1'b0, search_q[15:8]};
	assign tilt_step_sum = {1'b0, tilt_reg_q} + {1'b0, search_q[23:16]};

	always_comb begin
		srch_pan  = pan_reg_q;
		srch_tilt = tilt_reg_q;
		priority if (restart_q) begin
			srch_pan  = pan_lo;
			srch_tilt = TILT_CENTER;
		end else if (pan_reg_q >= pan_hi) begin
			srch_pan = pan_lo;
			priority if (tilt_reg_q >= tilt_hi)          srch_tilt = tilt_lo;
			else if (tilt_step_sum >= {1'b0, tilt_hi})   srch_tilt = tilt_hi;
			else                                         srch_tilt = tilt_step_sum[POS_W-1:0];
		end else begin
			priority if (pan_step_sum >= {1'b0, pan_hi}) srch_pan = pan_hi;
			else                                         srch_pan = pan_step_sum[POS_W-1:0];
		end
	end

	// Position and status state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_reg_q  <= PAN_CENTER;
			tilt_reg_q <= TILT_CENTER;
			restart_q  <= 1'b1;
			wait_q     <= '0;
			status_q   <= STATUS_SEARCHING;
			pan_ok_q   <= 1'b0;
		end else if (cmd.update) begin
			restart_q <= 1'b1;
			if (cmd.tilt_sel) begin
				tilt_reg_q <= new_pos;
				status_q   <= (pan_ok_q && !out_band) ? STATUS_ON_TARGET : STATUS_IN_VIEW;
			end else begin
				pan_reg_q <= new_pos;
				pan_ok_q  <= !out_band;
			end
		end else if (cmd.search) begin
			status_q <= STATUS_SEARCHING;
			if (move) begin
				wait_q     <= '0;
				restart_q  <= 1'b0;
				pan_reg_q  <= srch_pan;
				tilt_reg_q <= srch_tilt;
			end else begin
				wait_q <= wait_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			pan_out_q    <= pan_reg_q;
			tilt_out_q   <= tilt_reg_q;
			status_out_q <= status_q;
		end
	end

	assign status.fresh    = fresh_q;
	assign status.lock     = conf_q >= conf_thr_q;
	assign status.div_done = div_done && !div_busy;

	assign pan_position    = pan_out_q;
	assign tilt_position   = tilt_out_q;
	assign tracking_status = status_out_q;

endmodule

[src/ptt_ctrl.sv]
`include "assert_macros.svh"

module ptt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  ptt_pkg::ptt_status_t status,
	output ptt_pkg::ptt_cmd_t    cmd
);
	import ptt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_SEARCH,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_UPDATE,
		ST_PUBLISH
	} state_t;

	state_t state_q;
	logic   tilt_q;
	logic   out_valid_q;
	logic   out_free;

	// Result register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.tilt_sel = tilt_q;
		unique case (state_q)
			ST_IDLE:      cmd.load      = in_valid;
			ST_ERR:       cmd.calc_err  = 1'b1;
			ST_SEARCH:    cmd.search    = 1'b1;
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_DIV_WAIT:  ;
			ST_UPDATE:    cmd.update    = 1'b1;
			ST_PUBLISH:   cmd.publish   = out_free;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tilt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Result taken; a publish in the same cycle refills it below
			if (out_valid_q && !out_stall && state_q != ST_PUBLISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_ERR;
				end
				ST_ERR: begin
					priority if (!status.fresh) begin
						state_q <= ST_PUBLISH;
					end else if (!status.lock) begin
						state_q <= ST_SEARCH;
					end else begin
						tilt_q  <= 1'b0;
						state_q <= ST_DIV_START;
					end
				end
				ST_SEARCH:    state_q <= ST_PUBLISH;
				ST_DIV_START: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (status.div_done) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (!tilt_q) begin
						tilt_q  <= 1'b1;
						state_q <= ST_DIV_START;
					end else begin
						state_q <= ST_PUBLISH;
					end
				end
				ST_PUBLISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	`PTT_ASSERT_NEXT(a_publish_shows, cmd.publish, out_valid_q, "published result not shown")
	`PTT_ASSERT(a_done_in_wait, status.div_done |-> state_q == ST_DIV_WAIT, "stray divider done")

endmodule

[src/pan_tilt_tracking_controller.sv]
// Channel  Handshake                 Payload
// -------  ------------------------  ---------------------------------------------
// in       in_valid / in_stall       packet_fresh, confidence, centroid_x/y, pan_trim
// out      out_valid / out_stall     pan_position, tilt_position, tracking_status
// cfg      cfg_write_en              cfg_index, cfg_data
//
// One result per input transfer. A tick without a fresh packet passes the load,
// error and publish states; a search tick also passes the search state; a
// tracking tick makes one pass of the shared serial divider per axis (start,
// 8 quotient steps, hand-off), then publishes. One tick is in flight at a time.
// Reset is asynchronous, active low; registers return to their defaults and
// servos to center. A stalled result waits in the output register while the
// next tick is taken and worked; it finishes once that register frees up.
module pan_tilt_tracking_controller #(
	parameter logic [ptt_pkg::POS_W-1:0] PAN_CENTER  = ptt_pkg::PAN_CENTER_DEF,
	parameter logic [ptt_pkg::POS_W-1:0] TILT_CENTER = ptt_pkg::TILT_CENTER_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [ptt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              packet_fresh,
	input  logic [ptt_pkg::CONF_W-1:0]        confidence,
	input  logic [ptt_pkg::PIX_W-1:0]         centroid_x,
	input  logic [ptt_pkg::PIX_W-1:0]         centroid_y,
	input  logic signed [ptt_pkg::TRIM_W-1:0] pan_trim,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ptt_pkg::POS_W-1:0]         pan_position,
	output logic [ptt_pkg::POS_W-1:0]         tilt_position,
	output logic [ptt_pkg::STATUS_W-1:0]      tracking_status
);
	import ptt_pkg::*;

	ptt_cmd_t    cmd;
	ptt_status_t status;

	// Sequencer
	ptt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Registers, arithmetic and divider
	ptt_dp #(
		.PAN_CENTER  (PAN_CENTER),
		.TILT_CENTER (TILT_CENTER)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.packet_fresh    (packet_fresh),
		.confidence      (confidence),
		.centroid_x      (centroid_x),
		.centroid_y      (centroid_y),
		.pan_trim        (pan_trim),
		.cmd             (cmd),
		.status          (status),
		.pan_position    (pan_position),
		.tilt_position   (tilt_position),
		.tracking_status (tracking_status)
	);

endmodule

[tb/pan_tilt_tracking_controller_test.sv]
`timescale 1ns / 1ps

module pan_tilt_tracking_controller_test;
	import ptt_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int DIRECTED_ROWS = 21;
	localparam int PHASES        = 9;
	localparam int PHASE_TICKS   = 140;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PAN_BIAS      = 25;
	localparam int PAN_ERR_CLAMP = 127;
	localparam logic [TRIM_W-1:0] TRIM_MIN = 7'h40;
	localparam logic [TRIM_W-1:0] TRIM_MAX = 7'h3F;

	// One control tick as offered on the input channel
	typedef struct packed {
		logic              fresh;
		logic [CONF_W-1:0] conf;
		logic [PIX_W-1:0]  cx;
		logic [PIX_W-1:0]  cy;
		logic [TRIM_W-1:0] trim;
	} tick_t;

	// Servo command as returned on the output channel
	typedef struct packed {
		logic [POS_W-1:0]    pan;
		logic [POS_W-1:0]    tilt;
		logic [STATUS_W-1:0] status;
	} servo_cmd_t;

	// Directed row: tick plus an optional hand-written command
	typedef struct packed {
		tick_t      tick;
		logic       typed;
		servo_cmd_t cmd;
	} vector_t;

	typedef enum int {SETUP_RANDOM, SETUP_HIGH, SETUP_LOW, SETUP_FAST_RASTER} setup_kind_t;
	typedef enum int {BURST_TRACK, BURST_SEARCH, BURST_NOISE} burst_t;

	localparam servo_cmd_t NO_CMD = '0;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic                  packet_fresh = 1'b0;
	logic [CONF_W-1:0]     confidence   = '0;
	logic [PIX_W-1:0]      centroid_x   = '0;
	logic [PIX_W-1:0]      centroid_y   = '0;
	logic [TRIM_W-1:0]     pan_trim     = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [POS_W-1:0]      pan_position;
	logic [POS_W-1:0]      tilt_position;
	logic [STATUS_W-1:0]   tracking_status;

	// Hand-written command travels with the tick it belongs to
	logic       row_typed = 1'b0;
	servo_cmd_t row_cmd   = '0;

	int  snd_idle_pct = 0;
	int  rcv_idle_pct = 0;
	bit  hold_armed   = 1'b0;
	bit  hold_done    = 1'b0;
	int  fail_count   = 0;

	servo_cmd_t pending_cmds [$];

	// Shadow registers
	logic [7:0]  thr_cfg;
	logic [7:0]  pan_tgt_cfg;
	logic [7:0]  tilt_tgt_cfg;
	logic [15:0] dead_cfg;
	logic [15:0] gain_cfg;
	logic [15:0] pan_lim_cfg;
	logic [15:0] tilt_lim_cfg;
	logic [25:0] search_cfg;

	// Tracker state
	logic [POS_W-1:0]    pan_now;
	logic [POS_W-1:0]    tilt_now;
	logic [STATUS_W-1:0] status_now;
	logic                raster_restart;
	logic [7:0]          search_count;

	vector_t directed_plan [DIRECTED_ROWS] = '{
		// idle tick straight out of reset
		'{'{1'b0, 8'd255, 8'd255, 8'd255, TRIM_MAX}, 1'b1,
			'{PAN_CENTER_DEF, TILT_CENTER_DEF, STATUS_SEARCHING}},
		// zero error on both axes
		'{'{1'b1, 8'd255, 8'd105, 8'd120, 7'h00}, 1'b1,
			'{PAN_CENTER_DEF, TILT_CENTER_DEF, STATUS_ON_TARGET}},
		// no packet: everything holds
		'{'{1'b0, 8'd0, 8'd0, 8'd0, TRIM_MIN}, 1'b1,
			'{PAN_CENTER_DEF, TILT_CENTER_DEF, STATUS_ON_TARGET}},
		// one below threshold: search delay starts counting
		'{'{1'b1, 8'd49, 8'd200, 8'd10, 7'h15}, 1'b1,
			'{PAN_CENTER_DEF, TILT_CENTER_DEF, STATUS_SEARCHING}},
		// exactly at threshold, both errors on the deadband edge
		'{'{1'b1, 8'd50, 8'd111, 8'd126, 7'h00}, 1'b1,
			'{PAN_CENTER_DEF, TILT_CENTER_DEF, STATUS_ON_TARGET}},
		// just outside pan deadband: minimum step of one
		'{'{1'b1, 8'd50, 8'd112, 8'd120, 7'h00}, 1'b1,
			'{8'd128, TILT_CENTER_DEF, STATUS_IN_VIEW}},
		// field extremes, pan error clamp both ways
		'{'{1'b1, 8'd255, 8'd255, 8'd128, TRIM_MAX}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd200, 8'd0, 8'd0, TRIM_MIN}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd128, 8'd207, 8'd255, TRIM_MAX}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd77, 8'd208, 8'd99, TRIM_MIN}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd51, 8'd104, 8'd114, 7'h00}, 1'b0, NO_CMD},
		// low confidence run until the search delay runs out
		'{'{1'b1, 8'd0, 8'd0, 8'd255, 7'h2A}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd1, 8'd255, 8'd0, 7'h55}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd48, 8'd17, 8'd240, 7'h7F}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd49, 8'd90, 8'd33, 7'h01}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd0, 8'd128, 8'd128, 7'h40}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd33, 8'd64, 8'd200, 7'h3F}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd12, 8'd222, 8'd5, 7'h10}, 1'b0, NO_CMD},
		'{'{1'b1, 8'd7, 8'd9, 8'd77, 7'h6C}, 1'b0, NO_CMD},
		// first search move: pan minimum, tilt center
		'{'{1'b1, 8'd49, 8'd150, 8'd150, 7'h00}, 1'b1,
			'{8'd0, TILT_CENTER_DEF, STATUS_SEARCHING}},
		// lock again, re-arms the raster start
		'{'{1'b1, 8'd255, 8'd105, 8'd120, 7'h00}, 1'b0, NO_CMD}
	};

	pan_tilt_tracking_controller dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void reset_tracker();
		thr_cfg        = RST_CONF_THRESHOLD;
		pan_tgt_cfg    = RST_PAN_TARGET;
		tilt_tgt_cfg   = RST_TILT_TARGET;
		dead_cfg       = RST_ALLOWED_ERRORS;
		gain_cfg       = RST_AXIS_GAINS;
		pan_lim_cfg    = RST_PAN_LIMITS;
		tilt_lim_cfg   = RST_TILT_LIMITS;
		search_cfg     = RST_SEARCH_SETUP;
		pan_now        = PAN_CENTER_DEF;
		tilt_now       = TILT_CENTER_DEF;
		status_now     = STATUS_SEARCHING;
		raster_restart = 1'b1;
		search_count   = 8'd0;
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
		REG_CONF_THRESHOLD: thr_cfg      = val[7:0];
		REG_PAN_TARGET:     pan_tgt_cfg  = val[7:0];
		REG_TILT_TARGET:    tilt_tgt_cfg = val[7:0];
		REG_ALLOWED_ERRORS: dead_cfg     = val[15:0];
		REG_AXIS_GAINS:     gain_cfg     = val[15:0];
		REG_PAN_LIMITS:     pan_lim_cfg  = val[15:0];
		REG_TILT_LIMITS:    tilt_lim_cfg = val[15:0];
		REG_SEARCH_SETUP:   search_cfg   = val;
		default: ;
		endcase
	endfunction

	// Proportional step for one axis, clamped to its limits (min checked first)
	function automatic logic [POS_W-1:0] axis_move(input logic [POS_W-1:0] pos,
		input int err, input logic [7:0] dead, input logic [7:0] gain, input logic rev,
		input logic [7:0] lo, input logic [7:0] hi, output logic on_tgt);
		int d, g, stp, p;
		d      = int'(dead);
		g      = (gain == 8'd0) ? 1 : int'(gain);
		stp    = 0;
		on_tgt = 1'b0;
		if (err > d) begin
			stp = err / g;
			if (stp == 0) stp = 1;
		end else if (err < -d) begin
			stp = err / g;
			if (stp == 0) stp = -1;
		end else begin
			on_tgt = 1'b1;
		end
		p = rev ? int'(pos) - stp : int'(pos) + stp;
		if (p < int'(lo)) p = int'(lo);
		else if (p > int'(hi)) p = int'(hi);
		return p[7:0];
	endfunction

	// Advance the tracker by one tick and return the servo command it yields
	function automatic servo_cmd_t track_tick(input tick_t t);
		logic [7:0] diff, pan_lo, pan_hi, tilt_lo, tilt_hi;
		int         perr, terr, p, q;
		logic       pan_ok, tilt_ok;
		pan_lo  = pan_lim_cfg[7:0];
		pan_hi  = pan_lim_cfg[15:8];
		tilt_lo = tilt_lim_cfg[7:0];
		tilt_hi = tilt_lim_cfg[15:8];
		if (t.fresh) begin
			status_now = STATUS_SEARCHING;
			if (t.conf >= thr_cfg) begin
				// tracking: pan error wraps to a signed byte before trim and bias
				diff = t.cx - pan_tgt_cfg;
				perr = int'($signed(t.trim)) - PAN_BIAS + int'($signed(diff));
				terr = int'(t.cy) - int'(tilt_tgt_cfg);
				if (perr < -PAN_ERR_CLAMP) perr = -PAN_ERR_CLAMP;
				else if (perr > PAN_ERR_CLAMP) perr = PAN_ERR_CLAMP;
				raster_restart = 1'b1;
				pan_now = axis_move(pan_now, perr, dead_cfg[7:0], gain_cfg[7:0],
					search_cfg[24], pan_lo, pan_hi, pan_ok);
				tilt_now = axis_move(tilt_now, terr, dead_cfg[15:8], gain_cfg[15:8],
					search_cfg[25], tilt_lo, tilt_hi, tilt_ok);
				status_now = (pan_ok && tilt_ok) ? STATUS_ON_TARGET : STATUS_IN_VIEW;
			end else begin
				// search: delayed raster sweep
				search_count = search_count + 8'd1;
				if (search_count > search_cfg[7:0]) begin
					search_count = 8'd0;
					if (raster_restart) begin
						raster_restart = 1'b0;
						p = int'(pan_lo);
						q = int'(TILT_CENTER_DEF);
					end else begin
						p = int'(pan_now);
						q = int'(tilt_now);
						if (p >= int'(pan_hi)) begin
							p = int'(pan_lo);
							if (q >= int'(tilt_hi)) begin
								q = int'(tilt_lo);
							end else begin
								q = q + int'(search_cfg[23:16]);
								if (q >= int'(tilt_hi)) q = int'(tilt_hi);
							end
						end else begin
							p = p + int'(search_cfg[15:8]);
							if (p >= int'(pan_hi)) p = int'(pan_hi);
						end
					end
					pan_now  = p[7:0];
					tilt_now = q[7:0];
				end
			end
		end
		return '{pan_now, tilt_now, status_now};
	endfunction

	// Random tick shaped by the kind of burst it belongs to
	function automatic tick_t random_tick(input burst_t kind);
		tick_t t;
		int    reach, off, pix;
		t = tick_t'($urandom);
		if (kind == BURST_SEARCH && thr_cfg == 8'd0) kind = BURST_TRACK;
		case (kind)
		BURST_TRACK: begin
			t.fresh = 1'b1;
			t.conf  = 8'($urandom_range(255, int'(thr_cfg)));
			// aim near the deadband edges half of the time
			if ($urandom_range(1) != 0) begin
				reach = int'(dead_cfg[7:0]) + 4;
				off   = int'($urandom_range(2 * reach)) - reach;
				pix   = int'(pan_tgt_cfg) + PAN_BIAS - int'($signed(t.trim)) + off;
				t.cx  = pix[7:0];
			end
			if ($urandom_range(1) != 0) begin
				reach = int'(dead_cfg[15:8]) + 4;
				off   = int'($urandom_range(2 * reach)) - reach;
				pix   = int'(tilt_tgt_cfg) + off;
				t.cy  = pix[7:0];
			end
		end
		BURST_SEARCH: begin
			t.fresh = 1'b1;
			t.conf  = 8'($urandom_range(int'(thr_cfg) - 1, 0));
		end
		default: ;
		endcase
		return t;
	endfunction

	function automatic logic [15:0] random_limits();
		logic [7:0] lo, hi, tmp;
		lo = 8'($urandom);
		hi = 8'($urandom);
		// mostly ordered, sometimes reversed
		if ($urandom_range(4) != 0 && lo > hi) begin
			tmp = lo;
			lo  = hi;
			hi  = tmp;
		end
		return {hi, lo};
	endfunction

	function automatic logic [7:0] random_gain();
		if ($urandom_range(7) == 0) return 8'd0;
		if ($urandom_range(3) == 0) return 8'($urandom);
		return 8'($urandom_range(16, 1));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		apply_setting(idx, val);
		@(negedge clk);
	endtask

	task automatic program_setup(input setup_kind_t kind);
		logic [7:0]  thr, pt, tt, dly, pstep, tstep;
		logic [15:0] dead, gains, plim, tlim;
		logic [25:0] srch;
		case (kind)
		SETUP_HIGH: begin
			thr   = 8'd255;
			pt    = 8'd255;
			tt    = 8'd255;
			dead  = 16'hFFFF;
			gains = 16'hFFFF;
			plim  = 16'hFFFF;
			tlim  = 16'hFF00;
			// delay 255 never moves, both axes reversed
			srch  = 26'h3FFFFFF;
		end
		SETUP_LOW: begin
			thr   = 8'd0;
			pt    = 8'd0;
			tt    = 8'd0;
			dead  = 16'h0000;
			gains = 16'h0000;
			plim  = 16'h0000;
			tlim  = 16'h00FF;
			srch  = 26'h0000000;
		end
		SETUP_FAST_RASTER: begin
			thr   = 8'd128;
			pt    = 8'd128;
			tt    = 8'd128;
			dead  = 16'h0303;
			gains = 16'h0402;
			plim  = 16'hE010;
			tlim  = 16'h30C0;
			srch  = 26'h1FF4000;
		end
		default: begin
			thr   = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(230, 20));
			pt    = 8'($urandom);
			tt    = 8'($urandom);
			dead  = {8'($urandom_range(20)), 8'($urandom_range(20))};
			gains = {random_gain(), random_gain()};
			plim  = random_limits();
			tlim  = random_limits();
			dly   = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
			pstep = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(96, 8));
			tstep = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(96, 8));
			srch  = {2'($urandom), tstep, pstep, dly};
		end
		endcase
		write_reg(REG_CONF_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(REG_PAN_TARGET, CFG_DATA_W'(pt));
		write_reg(REG_TILT_TARGET, CFG_DATA_W'(tt));
		write_reg(REG_ALLOWED_ERRORS, CFG_DATA_W'(dead));
		write_reg(REG_AXIS_GAINS, CFG_DATA_W'(gains));
		write_reg(REG_PAN_LIMITS, CFG_DATA_W'(plim));
		write_reg(REG_TILT_LIMITS, CFG_DATA_W'(tlim));
		write_reg(REG_SEARCH_SETUP, srch);
		cfg_write_en <= 1'b0;
	endtask

	// Offer one tick after a random gap and hold it until the transfer
	task automatic send_tick(input tick_t t, input logic typed, input servo_cmd_t cmd);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		packet_fresh <= t.fresh;
		confidence   <= t.conf;
		centroid_x   <= t.cx;
		centroid_y   <= t.cy;
		pan_trim     <= t.trim;
		row_typed    <= typed;
		row_cmd      <= cmd;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
	endtask

	// Main sequence
	initial begin
		tick_t       t;
		burst_t      kind;
		setup_kind_t setup;
		int          sent, run, r;
		reset_tracker();
		snd_idle_pct = 7;
		rcv_idle_pct = 84;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[i])
			send_tick(directed_plan[i].tick, directed_plan[i].typed, directed_plan[i].cmd);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 3) begin
				snd_idle_pct = 84;
				rcv_idle_pct = 7;
			end
			if (ph == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			if (ph > 0) begin
				case (ph)
				1: setup = SETUP_HIGH;
				2: setup = SETUP_LOW;
				3: setup = SETUP_FAST_RASTER;
				default: setup = SETUP_RANDOM;
				endcase
				drain();
				program_setup(setup);
			end
			// long output hold-off so the block backs up into its input
			if (ph == 6) hold_armed = 1'b1;

			// bursts of tracking or search ticks, with some noise
			sent = 0;
			while (sent < PHASE_TICKS) begin
				r    = int'($urandom_range(9));
				kind = (r < 4) ? BURST_TRACK : (r < 8) ? BURST_SEARCH : BURST_NOISE;
				run  = int'($urandom_range(40, 1));
				repeat (run) begin
					t = random_tick(kind);
					send_tick(t, 1'b0, NO_CMD);
					if (t.fresh) sent++;
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Output stall: one long hold when armed, otherwise random
	initial begin
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		servo_cmd_t want;
		if (in_valid && !in_stall) begin
			want = track_tick('{packet_fresh, confidence, centroid_x, centroid_y, pan_trim});
			if (row_typed) want = row_cmd;
			pending_cmds.push_back(want);
		end
		if (out_valid && !out_stall) begin
			if (pending_cmds.size() == 0) begin
				$error("unexpected result: pan_position %0d tilt_position %0d tracking_status %0d",
					pan_position, tilt_position, tracking_status);
				fail_count++;
			end else begin
				want = pending_cmds.pop_front();
				if (pan_position !== want.pan) begin
					$error("pan_position: expected %0d, actual %0d", want.pan, pan_position);
					fail_count++;
				end
				if (tilt_position !== want.tilt) begin
					$error("tilt_position: expected %0d, actual %0d", want.tilt, tilt_position);
					fail_count++;
				end
				if (tracking_status !== want.status) begin
					$error("tracking_status: expected %0d, actual %0d", want.status,
						tracking_status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too many cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

endmodule
